[rtl/lbe_pkg.sv]
// ----------------------------------------------------------------------------
// lbe_pkg
// Shared types, codes, microcode program and constant helpers for the
// shifted Legendre basis evaluator.
// ----------------------------------------------------------------------------
package lbe_pkg;

  // output format: signed Q5.16
  localparam int OUT_W   = 22;
  localparam int OUT_MAX = 2097151;
  localparam int OUT_MIN = -2097152;

  // sqrt(2m+1) as unsigned Q16, m <= 63, fits in 20 bits
  localparam int SCALE_W = 20;

  // sequencer step codes
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_IDLE = 4'd0;
  localparam logic [PC_W-1:0] ST_L0   = 4'd1;
  localparam logic [PC_W-1:0] ST_L1   = 4'd2;
  localparam logic [PC_W-1:0] ST_L2   = 4'd3;
  localparam logic [PC_W-1:0] ST_L3   = 4'd4;
  localparam logic [PC_W-1:0] ST_L4   = 4'd5;
  localparam logic [PC_W-1:0] ST_L5   = 4'd6;
  localparam logic [PC_W-1:0] ST_FIN0 = 4'd7;
  localparam logic [PC_W-1:0] ST_FIN1 = 4'd8;

  // multiplier operand A select
  localparam logic [1:0] MA_B = 2'd0;
  localparam logic [1:0] MA_A = 2'd1;
  localparam logic [1:0] MA_T = 2'd2;
  localparam logic [1:0] MA_H = 2'd3;

  // multiplier operand B select
  localparam logic [2:0] MB_X     = 3'd0;
  localparam logic [2:0] MB_N     = 3'd1;
  localparam logic [2:0] MB_N2P1  = 3'd2;
  localparam logic [2:0] MB_RECIP = 3'd3;
  localparam logic [2:0] MB_SCALE = 3'd4;

  // branch kinds
  localparam logic [2:0] BR_NEXT     = 3'd0;
  localparam logic [2:0] BR_GO       = 3'd1;
  localparam logic [2:0] BR_EXIT     = 3'd2;  // to target once n >= degree
  localparam logic [2:0] BR_WAIT_IN  = 3'd3;  // to target when an input word arrives
  localparam logic [2:0] BR_WAIT_OUT = 3'd4;  // to target when the output slot is free

  // one control word of the program
  typedef struct packed {
    logic            mul_en;
    logic [1:0]      ma_sel;
    logic [2:0]      mb_sel;
    logic            t_ld;
    logic            acc_ld;
    logic            h_ld;
    logic            b_ld;
    logic            res_ld;
    logic [2:0]      br;
    logic [PC_W-1:0] target;
  } uop_t;

  // datapath controls, gated by the sequencer
  typedef struct packed {
    logic       ld_in;
    logic       mul_en;
    logic [1:0] ma_sel;
    logic [2:0] mb_sel;
    logic       t_ld;
    logic       acc_ld;
    logic       h_ld;
    logic       b_ld;
    logic       res_ld;
  } dp_ctl_t;

  // Program ROM: six steps per recurrence iteration, two to scale and store.
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '0;
    unique case (pc)
      ST_IDLE: begin
        u.br     = BR_WAIT_IN;
        u.target = ST_L0;
      end
      ST_L0: begin  // x*b, leave the loop when done
        u.mul_en = 1'b1;
        u.ma_sel = MA_B;
        u.mb_sel = MB_X;
        u.br     = BR_EXIT;
        u.target = ST_FIN0;
      end
      ST_L1: begin  // t = round(x*b), start n*a
        u.t_ld   = 1'b1;
        u.mul_en = 1'b1;
        u.ma_sel = MA_A;
        u.mb_sel = MB_N;
        u.br     = BR_NEXT;
      end
      ST_L2: begin  // acc = -n*a, start (2n+1)*t
        u.acc_ld = 1'b1;
        u.mul_en = 1'b1;
        u.ma_sel = MA_T;
        u.mb_sel = MB_N2P1;
        u.br     = BR_NEXT;
      end
      ST_L3: begin  // h = clamp(acc + (2n+1)*t)
        u.h_ld = 1'b1;
        u.br   = BR_NEXT;
      end
      ST_L4: begin  // h / (n+1) by reciprocal
        u.mul_en = 1'b1;
        u.ma_sel = MA_H;
        u.mb_sel = MB_RECIP;
        u.br     = BR_NEXT;
      end
      ST_L5: begin  // shift a <- b, b <- new term, n++
        u.b_ld   = 1'b1;
        u.br     = BR_GO;
        u.target = ST_L0;
      end
      ST_FIN0: begin  // b * sqrt(2m+1)
        u.mul_en = 1'b1;
        u.ma_sel = MA_B;
        u.mb_sel = MB_SCALE;
        u.br     = BR_NEXT;
      end
      ST_FIN1: begin
        u.res_ld = 1'b1;
        u.br     = BR_WAIT_OUT;
        u.target = ST_IDLE;
      end
      default: begin
        u.br     = BR_GO;
        u.target = ST_IDLE;
      end
    endcase
    return u;
  endfunction

  // sqrt(2m+1) in Q16, rounded to nearest; evaluated at elaboration only
  function automatic logic [SCALE_W-1:0] scale_q16(input int m);
    longint unsigned v;
    longint unsigned rem;
    longint unsigned r;
    longint unsigned bitv;
    v    = 64'(2 * m + 1) << 32;
    rem  = v;
    r    = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r   = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (v - r * r > r) begin
      r = r + 64'd1;
    end
    return SCALE_W'(r);
  endfunction

endpackage

[rtl/lbe_datapath.sv]
// ----------------------------------------------------------------------------
// lbe_datapath
// Operand registers, one shared signed multiplier, rounding, clamps and the
// reciprocal and scale tables for the Bonnet recurrence.
// ----------------------------------------------------------------------------
module lbe_datapath #(
  parameter int MAX_DEGREE = 63,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  lbe_pkg::dp_ctl_t                 ctl,
  input  logic [5:0]                       degree,
  input  logic [16:0]                      position,
  output logic                             n_done,
  output logic signed [lbe_pkg::OUT_W-1:0] value
);
  import lbe_pkg::*;

  localparam int DEG_LIM = (MAX_DEGREE < 63) ? MAX_DEGREE : 63;
  localparam int NW      = (DEG_LIM < 2) ? 1 : $clog2(DEG_LIM + 1);
  localparam int TBL     = 1 << NW;
  localparam int PW      = FRAC_BITS + 4;    // x, a, b, t: within +-4.0
  localparam int HW      = FRAC_BITS + 11;   // acc, h: within +-756
  localparam int MBW     = (FRAC_BITS + 2 > SCALE_W + 1) ? FRAC_BITS + 2 : SCALE_W + 1;
  localparam int MW      = HW + MBW;         // product
  localparam int SHL     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 1;

  localparam logic signed [PW-1:0] ONE     = PW'(1) << FRAC_BITS;
  localparam logic signed [MW-1:0] HALF    = MW'(1) << (FRAC_BITS - 1);
  localparam logic signed [MW-1:0] HALF_M1 = HALF - MW'(1);
  localparam logic signed [MW-1:0] BLIM    = MW'(4) << FRAC_BITS;
  localparam logic signed [MW-1:0] BLIM_N  = -BLIM;
  localparam logic signed [MW-1:0] VMAX    = MW'(OUT_MAX);
  localparam logic signed [MW-1:0] VMIN    = MW'(OUT_MIN);

  logic signed [PW-1:0] x, a, b, t;
  logic signed [HW-1:0] acc, h;
  logic [NW-1:0]        n, deg;
  logic signed [MW-1:0] prod;

  // constant tables
  logic [FRAC_BITS-1:0] recip [TBL];
  logic [SCALE_W-1:0]   scale [TBL];

  for (genvar k = 0; k < TBL; k++) begin : g_tbl
    if (k >= 2 && k <= DEG_LIM) begin : g_rc
      localparam longint unsigned KV = k;
      localparam longint unsigned RV = ((64'd1 << FRAC_BITS) + KV / 2) / KV;
      assign recip[k] = FRAC_BITS'(RV);
    end else begin : g_rz
      assign recip[k] = '0;
    end
    assign scale[k] = scale_q16(k);
  end

  // input mapping: clamp position and degree, x = 2t - 1 rescaled to QF
  logic [16:0]          pos_c;
  logic signed [18:0]   x16;
  logic signed [PW-1:0] x_in;
  logic [NW-1:0]        deg_in;

  assign pos_c  = (position > 17'd65536) ? 17'd65536 : position;
  assign x16    = $signed({1'b0, pos_c, 1'b0}) - 19'sd65536;
  assign deg_in = ({1'b0, degree} > 7'(DEG_LIM)) ? NW'(DEG_LIM) : degree[NW-1:0];

  if (FRAC_BITS >= 16) begin : g_xup
    assign x_in = PW'(x16) <<< SHL;
  end else begin : g_xdn
    localparam logic signed [18:0] XH   = 19'sd1 <<< (SHR - 1);
    localparam logic signed [18:0] XHM1 = XH - 19'sd1;
    logic signed [18:0] xs;
    assign xs   = x16 + (x16[18] ? XHM1 : XH);
    assign x_in = PW'(xs >>> SHR);
  end

  // multiplier operands
  logic [NW:0]           n1;
  logic signed [HW-1:0]  ma;
  logic signed [MBW-1:0] mb;
  logic signed [MW-1:0]  mul_out;

  assign n1 = (NW + 1)'(n) + 1'b1;

  always_comb begin
    case (ctl.ma_sel)
      MA_B:    ma = HW'(b);
      MA_A:    ma = HW'(a);
      MA_T:    ma = HW'(t);
      default: ma = h;
    endcase
  end

  always_comb begin
    case (ctl.mb_sel)
      MB_X:     mb = MBW'(x);
      MB_N:     mb = $signed(MBW'(n));
      MB_N2P1:  mb = $signed(MBW'({n, 1'b1}));
      MB_RECIP: mb = $signed(MBW'(recip[n1[NW-1:0]]));
      MB_SCALE: mb = $signed(MBW'(scale[deg]));
      default:  mb = '0;
    endcase
  end

  assign mul_out = ma * mb;

  // round half away from zero, back by FRAC_BITS
  logic signed [MW-1:0] rsum, rnd;
  assign rsum = prod + (prod[MW-1] ? HALF_M1 : HALF);
  assign rnd  = rsum >>> FRAC_BITS;

  // Pn clamp to +-4.0
  logic signed [MW-1:0] b_cl;
  assign b_cl = (rnd > BLIM) ? BLIM : ((rnd < BLIM_N) ? BLIM_N : rnd);

  // h = (2n+1)t - n a, clamped to +-4(n+1)
  logic signed [MW-1:0] hsum, hlim, h_cl;
  assign hsum = MW'(acc) + prod;
  assign hlim = $signed(MW'(n1)) <<< (FRAC_BITS + 2);
  assign h_cl = (hsum > hlim) ? hlim : ((hsum < -hlim) ? -hlim : hsum);

  // output saturation
  logic signed [MW-1:0] v_sat;
  assign v_sat = (rnd > VMAX) ? VMAX : ((rnd < VMIN) ? VMIN : rnd);

  assign n_done = (n >= deg);

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      x   <= x_in;
      a   <= ONE;
      b   <= (deg_in == '0) ? ONE : x_in;
      n   <= NW'(1);
      deg <= deg_in;
    end
    if (ctl.mul_en) begin
      prod <= mul_out;
    end
    if (ctl.t_ld) begin
      t <= PW'(rnd);
    end
    if (ctl.acc_ld) begin
      acc <= HW'(-prod);
    end
    if (ctl.h_ld) begin
      h <= HW'(h_cl);
    end
    if (ctl.b_ld) begin
      a <= b;
      b <= PW'(b_cl);
      n <= n1[NW-1:0];
    end
    if (ctl.res_ld) begin
      value <= OUT_W'(v_sat);
    end
  end

endmodule

[rtl/legendre_basis_eval.sv]
// ----------------------------------------------------------------------------
// legendre_basis_eval
// Orthonormal shifted Legendre polynomial sqrt(2m+1)*Pm(2t-1), signed Q5.16.
// One word is in flight at a time: in_ready is high only in the idle step, so
//   a new word is taken only once the result of the last one is stored. For
//   degree 0 or 1 the loop is skipped; for degree m >= 2 the six-step recurrence
//   loop on the single shared multiplier runs for n = 1 to m-1, then ST_FIN0
//   scales and ST_FIN1 stores the result.
// Reset: rst clears the step counter and output valid; datapath needs none.
// ----------------------------------------------------------------------------
module legendre_basis_eval #(
  parameter int MAX_DEGREE = 63,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [5:0]                       degree,
  input  logic [16:0]                      position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [lbe_pkg::OUT_W-1:0] value
);
  import lbe_pkg::*;

  logic [PC_W-1:0] pc, pc_next;
  uop_t            uop;
  dp_ctl_t         ctl;
  logic            n_done;
  logic            out_free;
  logic            res_fire;

  // control word for this step
  assign uop      = ucode(pc);
  assign in_ready = (pc == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign res_fire = uop.res_ld && out_free;

  always_comb begin
    ctl.ld_in  = in_valid && in_ready;
    ctl.mul_en = uop.mul_en;
    ctl.ma_sel = uop.ma_sel;
    ctl.mb_sel = uop.mb_sel;
    ctl.t_ld   = uop.t_ld;
    ctl.acc_ld = uop.acc_ld;
    ctl.h_ld   = uop.h_ld;
    ctl.b_ld   = uop.b_ld;
    ctl.res_ld = res_fire;
  end

  // step counter with conditional jumps
  always_comb begin
    unique case (uop.br)
      BR_NEXT:     pc_next = pc + 1'b1;
      BR_GO:       pc_next = uop.target;
      BR_EXIT:     pc_next = n_done ? uop.target : pc + 1'b1;
      BR_WAIT_IN:  pc_next = in_valid ? uop.target : pc;
      BR_WAIT_OUT: pc_next = out_free ? uop.target : pc;
      default:     pc_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (res_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  lbe_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .ctl      (ctl),
    .degree   (degree),
    .position (position),
    .n_done   (n_done),
    .value    (value)
  );

  // a new result word only comes out of the final step
  a_rose_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == ST_FIN1)
    else $error("result word appeared outside the final step");

  // an accepted word starts the recurrence
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> pc == ST_L0)
    else $error("accepted word did not start the program");

  // the step counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= ST_FIN1)
    else $error("step counter left the program");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(value))
    else $error("pending result word was overwritten");

endmodule

[tb/sv/tb_legendre_basis_eval.sv]
// ----------------------------------------------------------------------------
// tb_legendre_basis_eval
// Self-checking bench for the shifted Legendre basis evaluator. A directed
// table covers degree 0 and 1, the position ends, over-range positions and
// the top degree. A random phase follows, weighted toward low degrees. Every
// result word is checked against a typed-in value or the fixed-point model below.
// Both handshakes idle at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
module tb_legendre_basis_eval;
  import lbe_pkg::*;

  localparam int FRAC        = 16;
  localparam int TOP_DEGREE  = 63;
  localparam int N_DIRECTED  = 18;
  localparam int N_RANDOM    = 800;
  localparam int IDLE_LIMIT  = 5000;   // cycles with no word moving
  localparam int DRAIN_WAIT  = 400;    // longer than the worst-case latency
  localparam int HOLD_CYCLES = 1000;   // long output stall

  typedef struct packed {
    logic [5:0]              deg;
    logic [16:0]             pos;
    logic                    known;
    logic signed [OUT_W-1:0] val;
  } dir_row_t;

  typedef struct {
    logic [5:0]              deg;
    logic [16:0]             pos;
    logic signed [OUT_W-1:0] val;
  } pending_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [5:0]              degree;
  logic [16:0]             position;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] value;

  pending_t pending_values[$];
  dir_row_t directed_rows[N_DIRECTED];
  int       error_count;
  int       idle_cycles;

  legendre_basis_eval dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .degree   (degree),
    .position (position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value    (value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point model of the evaluator
  // ---------------------------------------------------------------------------

  // shift right, rounding half away from zero
  function automatic longint round_shift(input longint v, input int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) begin
      return (v + half) >>> sh;
    end
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // 2^F / k, halves rounded up
  function automatic longint recip_q16(input longint k);
    return ((longint'(1) <<< FRAC) + k / 2) / k;
  endfunction

  // sqrt(2m+1) in Q16, rounded to nearest
  function automatic longint sqrt_coef_q16(input longint m);
    longint v;
    longint lo;
    longint hi;
    longint mid;
    v  = (2 * m + 1) <<< 32;
    lo = 0;
    hi = longint'(1) <<< 21;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (v - lo * lo > lo) begin
      lo = lo + 1;
    end
    return lo;
  endfunction

  // sqrt(2m+1) * Pm(2t-1) as saturated Q5.16
  function automatic logic signed [OUT_W-1:0] legendre_value(input logic [5:0] deg_in,
                                                             input logic [16:0] pos_in);
    longint m;
    longint t;
    longint one;
    longint x;
    longint a;
    longint b;
    longint prod;
    longint h;
    longint v;
    m   = longint'(deg_in);
    t   = longint'(pos_in);
    one = longint'(1) <<< FRAC;
    if (m > TOP_DEGREE) begin
      m = TOP_DEGREE;
    end
    if (t > 65536) begin
      t = 65536;
    end
    x = 2 * t - 65536;
    if (m == 0) begin
      b = one;
    end else begin
      a = one;
      b = x;
      // Bonnet's recurrence, with runaway clamps on h and on each term
      for (longint n = 1; n < m; n++) begin
        prod = round_shift(x * b, FRAC);
        h    = (2 * n + 1) * prod - n * a;
        h    = clamp_sym(h, 4 * (n + 1) * one);
        a    = b;
        b    = round_shift(h * recip_q16(n + 1), FRAC);
        b    = clamp_sym(b, 4 * one);
      end
    end
    v = round_shift(b * sqrt_coef_q16(m), FRAC);
    if (v > OUT_MAX) begin
      v = OUT_MAX;
    end
    if (v < OUT_MIN) begin
      v = OUT_MIN;
    end
    return OUT_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer one word, log its expected value on acceptance
  // ---------------------------------------------------------------------------
  task automatic offer_word(input logic [5:0] d, input logic [16:0] p,
                            input logic signed [OUT_W-1:0] want, input bit no_gap);
    int       gap;
    pending_t entry;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    degree   <= d;
    position <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    entry.deg = d;
    entry.pos = p;
    entry.val = want;
    pending_values.push_back(entry);
    @(negedge clk);
  endtask

  function automatic logic [5:0] pick_degree();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 6'($urandom_range(0, 8));
    end else if (r < 90) begin
      return 6'($urandom_range(9, 40));
    end
    return 6'($urandom_range(41, 63));
  endfunction

  function automatic logic [16:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 17'($urandom_range(0, 65536));
    end else if (r < 85) begin
      // ends of the interval, the midpoint and their neighbors
      case ($urandom_range(0, 5))
        0:       return 17'd0;
        1:       return 17'd1;
        2:       return 17'd32768;
        3:       return 17'd65535;
        4:       return 17'd65536;
        default: return 17'd65537;
      endcase
    end
    // full field, over-range values included
    return 17'($urandom_range(0, 131071));
  endfunction

  // stimulus
  initial begin
    logic [5:0]  d;
    logic [16:0] p;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    degree      <= '0;
    position    <= '0;
    error_count  = 0;

    // directed words; typed-in values are exact at degree 0 and 1
    directed_rows = '{
      '{6'd0,  17'd0,      1'b1, 22'sd65536},
      '{6'd0,  17'd65536,  1'b1, 22'sd65536},
      '{6'd0,  17'd131071, 1'b1, 22'sd65536},
      '{6'd1,  17'd0,      1'b1, -22'sd113512},
      '{6'd1,  17'd65536,  1'b1, 22'sd113512},
      '{6'd1,  17'd32768,  1'b1, 22'sd0},
      '{6'd1,  17'd65537,  1'b1, 22'sd113512},
      '{6'd1,  17'd131071, 1'b1, 22'sd113512},
      '{6'd2,  17'd32768,  1'b0, 22'sd0},
      '{6'd2,  17'd0,      1'b0, 22'sd0},
      '{6'd63, 17'd0,      1'b0, 22'sd0},
      '{6'd63, 17'd65536,  1'b0, 22'sd0},
      '{6'd63, 17'd131071, 1'b0, 22'sd0},
      '{6'd63, 17'd32768,  1'b0, 22'sd0},
      '{6'd63, 17'd1,      1'b0, 22'sd0},
      '{6'd62, 17'd65535,  1'b0, 22'sd0},
      '{6'd32, 17'd16384,  1'b0, 22'sd0},
      '{6'd5,  17'd100000, 1'b0, 22'sd0}
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].deg, directed_rows[i].pos,
                 directed_rows[i].known ? directed_rows[i].val
                                        : legendre_value(directed_rows[i].deg,
                                                         directed_rows[i].pos),
                 1'b0);
    end

    // random words; every fourth block of 40 goes back to back
    for (int i = 0; i < N_RANDOM; i++) begin
      d = pick_degree();
      p = pick_position();
      offer_word(d, p, legendre_value(d, p), ((i / 40) % 4) == 3);
    end
    in_valid <= 1'b0;

    while (pending_values.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("[legendre_basis_eval] OK");
    end else begin
      $display("[legendre_basis_eval] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, one long hold, compare each word
  // ---------------------------------------------------------------------------
  initial begin
    int       stall;
    int       received;
    pending_t head;
    out_ready <= 1'b0;
    received   = 0;
    // wait until reset has been seen and released
    while (rst !== 1'b0) begin
      @(negedge clk);
    end
    forever begin
      if (received == 150) begin
        stall = HOLD_CYCLES;
      end else if (((received / 50) % 4) == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) begin
        @(posedge clk);
      end
      received++;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result word, value %0d", $time, value);
        error_count++;
      end else begin
        head = pending_values.pop_front();
        if (value !== head.val) begin
          $display("%0t: value mismatch (degree %0d, position %0d): expected %0d, got %0d",
                   $time, head.deg, head.pos, head.val, value);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_values.size());
        $display("[legendre_basis_eval] ERROR");
        $finish;
      end
    end
  end

endmodule
